// ----- rtl/fpr_pkg.sv -----
// Shared constants and controller-to-datapath command type for the FIFO page replacement core.
package fpr_pkg;

    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // Fixed field widths on the ports
    localparam int PAGE_NUM_W = 16;
    localparam int SLOT_W     = 3;
    localparam int FAULT_W    = 16;

    typedef struct packed {
        logic step;   // take the presented reference and load the result register
    } t_dp_cmd;

endpackage

// ----- rtl/fifo_page_replacement_core.sv -----
// Top level of the FIFO page replacement core: controller and datapath.
//
//   channel   direction  handshake                    payload
//   in        input      i_in_valid / o_in_ready      i_page_number
//   out       output     o_out_valid / i_out_ready    o_hit, o_fault_counted,
//                                                     o_frame_slot, o_fault_total
//
// One reference per cycle while out is not stalled; each result appears in the cycle after its transfer.
// The compare across all frames and the pointer update complete in the cycle of the transfer.
// A single result register holds the output; a new reference is taken while it
// drains, so a stall on out stops in only while the register is full and not taken.
// Synchronous active-low reset zeroes all frames (so page 0 then hits) and clears pointer, filled flag and count.
module fifo_page_replacement_core
    import fpr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PAGE_NUM_W-1:0] i_page_number,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic                  o_fault_counted,
    output logic [SLOT_W-1:0]     o_frame_slot,
    output logic [FAULT_W-1:0]    o_fault_total
);

    t_dp_cmd w_cmd;

    fpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    fpr_dp #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_page_number   (i_page_number),
        .o_hit           (o_hit),
        .o_fault_counted (o_fault_counted),
        .o_frame_slot    (o_frame_slot),
        .o_fault_total   (o_fault_total)
    );

endmodule

// ----- rtl/fpr_ctrl.sv -----
// Handshake controller: tracks the result register and issues step commands.
module fpr_ctrl
    import fpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [0:0] {
        ST_EMPTY,
        ST_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Take a new reference whenever the result register is free or drains this cycle
    assign o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_FULL);
    assign o_cmd.step  = w_accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (w_accept) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (w_accept)         n_state = ST_FULL;
                else if (i_out_ready) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/fpr_dp.sv -----
// Datapath: frame registers, parallel compare, insert pointer, fault counter, result register.
module fpr_dp
    import fpr_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [PAGE_NUM_W-1:0] i_page_number,
    output logic                  o_hit,
    output logic                  o_fault_counted,
    output logic [SLOT_W-1:0]     o_frame_slot,
    output logic [FAULT_W-1:0]    o_fault_total
);

    localparam int PTR_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(NUM_FRAMES - 1);
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    logic [PAGE_BITS-1:0] r_frames [NUM_FRAMES];
    logic [PTR_W-1:0]     r_ptr;
    logic                 r_filled;
    logic [FAULT_W-1:0]   r_faults;

    logic                 r_hit;
    logic                 r_counted;
    logic [SLOT_W-1:0]    r_slot;

    logic [PAGE_BITS-1:0] w_page;
    logic                 w_found;
    logic [PTR_W-1:0]     w_match;
    logic [PTR_W-1:0]     w_slot;
    logic                 w_counted;
    logic [FAULT_W-1:0]   n_faults;

    assign w_page = PAGE_BITS'(i_page_number);

    // Lowest matching frame wins: scan downwards so the lowest index is assigned last
    always_comb begin
        w_found = 1'b0;
        w_match = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (r_frames[i] == w_page) begin
                w_found = 1'b1;
                w_match = PTR_W'(i);
            end
        end
    end

    assign w_slot    = w_found ? w_match : r_ptr;
    assign w_counted = !w_found && r_filled;
    assign n_faults  = (w_counted && (r_faults != FAULT_MAX)) ? r_faults + 1'b1 : r_faults;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_frames[i] <= '0;
            end
            r_ptr    <= '0;
            r_filled <= 1'b0;
            r_faults <= '0;
        end else if (i_cmd.step) begin
            r_faults <= n_faults;
            if (!w_found) begin
                r_frames[r_ptr] <= w_page;
                // Advance and wrap; the first wrap marks every frame as filled
                if (r_ptr == PTR_LAST) begin
                    r_ptr    <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_hit     <= w_found;
            r_counted <= w_counted;
            r_slot    <= SLOT_W'(w_slot);
        end
    end

    assign o_hit           = r_hit;
    assign o_fault_counted = r_counted;
    assign o_frame_slot    = r_slot;
    assign o_fault_total   = r_faults;

endmodule
